// ===== src/ssg_pkg.sv =====
package ssg_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;

  localparam int STEP_W  = 32;
  localparam int AMP_W   = 15;
  localparam int COUNT_W = 17;
  localparam int INDEX_W = 16;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [STEP_W-1:0]  phase_step;
    logic [AMP_W-1:0]   amplitude;
    logic [COUNT_W-1:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic               neg;
    logic [INDEX_W-1:0] index;
    logic               last;
  } tag_t;

  // quarter-wave entry k, taylor series in q2.30, evaluated at elaboration
  function automatic logic [31:0] rom_entry(input int unsigned k,
                                            input int unsigned addr_bits,
                                            input int unsigned sample_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic [63:0]        scale;
    logic [63:0]        mag;
    logic signed [63:0] acc;
    x     = (PI_Q30 * (64'(k) * 64'd2 + 64'd1) + (64'd2 << addr_bits)) >> (addr_bits + 2);
    x2    = (x * x + (64'd1 << 29)) >> 30;
    term  = x;
    acc   = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      prod = (term * x2) >> 30;
      unique case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if (n % 2 == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (64'(acc) > ONE_Q30) begin
      acc = signed'(ONE_Q30);
    end
    scale = (64'd1 << (sample_bits - 1)) - 64'd1;
    mag   = (64'(acc) * scale + (64'd1 << 29)) >> 30;
    return mag[31:0];
  endfunction

endpackage

// ===== src/ssg_ram.sv =====
module ssg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/ssg_rom_fill.sv =====
module ssg_rom_fill #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       busy_o,
  output logic                       wr_en_o,
  output logic [TABLE_ADDR_BITS-1:0] wr_addr_o,
  output logic [SAMPLE_BITS-1:0]     wr_data_o
);
  import ssg_pkg::*;

  localparam int ROW_BITS  = (TABLE_ADDR_BITS > 8) ? 8 : TABLE_ADDR_BITS;
  localparam int BANK_BITS = TABLE_ADDR_BITS - ROW_BITS;
  localparam int ROWS      = 1 << ROW_BITS;
  localparam int NBANK     = 1 << BANK_BITS;
  localparam int SEL_W     = (BANK_BITS > 0) ? BANK_BITS : 1;

  logic [SAMPLE_BITS-1:0]     tbl [NBANK][ROWS];
  logic [SAMPLE_BITS-1:0]     bank_q [NBANK];
  logic [TABLE_ADDR_BITS:0]   cnt_q, cnt_d;
  logic [TABLE_ADDR_BITS-1:0] addr_q;
  logic                       wv_q;
  logic                       busy_q, busy_d;
  logic                       issue;
  logic [SEL_W-1:0]           sel;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    for (genvar r = 0; r < ROWS; r++) begin : g_row
      assign tbl[b][r] = SAMPLE_BITS'(rom_entry(b * ROWS + r, TABLE_ADDR_BITS, SAMPLE_BITS));
    end
    always_ff @(posedge clk_i) begin
      if (issue) begin
        bank_q[b] <= tbl[b][cnt_q[ROW_BITS-1:0]];
      end
    end
  end

  assign issue  = busy_q && !cnt_q[TABLE_ADDR_BITS];
  assign cnt_d  = issue ? cnt_q + 1'b1 : cnt_q;
  assign busy_d = (wv_q && (addr_q == '1)) ? 1'b0 : busy_q;
  assign sel    = SEL_W'(addr_q >> ROW_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wv_q   <= 1'b0;
      busy_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      wv_q   <= issue;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      addr_q <= cnt_q[TABLE_ADDR_BITS-1:0];
    end
  end

  assign busy_o    = busy_q;
  assign wr_en_o   = wv_q;
  assign wr_addr_o = addr_q;
  assign wr_data_o = bank_q[sel];

  a_write_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> busy_o)
    else $error("table write outside fill");

  a_fill_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("fill restarted");

endmodule

// ===== src/ssg_cfg_regs.sv =====
module ssg_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ssg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ssg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output ssg_pkg::cfg_t                   cfg_o
);
  import ssg_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (reg_sel)
        REG_PHASE_STEP:   cfg_d.phase_step   = pwdata[STEP_W-1:0];
        REG_AMPLITUDE:    cfg_d.amplitude    = pwdata[AMP_W-1:0];
        REG_SAMPLE_COUNT: cfg_d.sample_count = pwdata[COUNT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PHASE_STEP:   prdata = APB_DATA_W'(cfg_q.phase_step);
      REG_AMPLITUDE:    prdata = APB_DATA_W'(cfg_q.amplitude);
      REG_SAMPLE_COUNT: prdata = APB_DATA_W'(cfg_q.sample_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step   <= '0;
      cfg_q.amplitude    <= '0;
      cfg_q.sample_count <= COUNT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ssg_phase.sv =====
module ssg_phase #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       restart_i,
  input  ssg_pkg::cfg_t              cfg_i,
  output logic [TABLE_ADDR_BITS-1:0] rd_addr_o,
  output ssg_pkg::tag_t              tag_o
);
  import ssg_pkg::*;

  logic [PHASE_BITS-1:0]      phase_q, phase_d, eff_phase;
  logic [INDEX_W-1:0]         idx_q, idx_d, eff_idx, cnt_m1;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] tbl_addr;
  logic                       last;

  always_comb begin
    if (cfg_i.sample_count == '0) begin
      cnt_m1 = '0;
    end else if (cfg_i.sample_count[INDEX_W]) begin
      cnt_m1 = '1;
    end else begin
      cnt_m1 = cfg_i.sample_count[INDEX_W-1:0] - 1'b1;
    end
  end

  assign eff_phase = restart_i ? '0 : phase_q;
  assign eff_idx   = restart_i ? '0 : idx_q;
  assign quad      = eff_phase[PHASE_BITS-1 -: 2];
  assign tbl_addr  = eff_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign last      = eff_idx >= cnt_m1;

  // odd quadrants run the table backwards
  assign rd_addr_o = quad[0] ? ~tbl_addr : tbl_addr;

  assign tag_o.neg   = quad[1];
  assign tag_o.index = eff_idx;
  assign tag_o.last  = last;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (accept_i) begin
      if (last) begin
        phase_d = '0;
        idx_d   = '0;
      end else begin
        phase_d = eff_phase + PHASE_BITS'(cfg_i.phase_step);
        idx_d   = eff_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  a_wrap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && tag_o.last |=> idx_q == '0 && phase_q == '0)
    else $error("no wrap after last sample");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !restart_i && !tag_o.last |=> idx_q == $past(idx_q) + 1'b1)
    else $error("index did not advance");

endmodule

// ===== src/ssg_scale.sv =====
module ssg_scale #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  ssg_pkg::tag_t                   tag_i,
  input  logic [SAMPLE_BITS-1:0]          entry_i,
  input  logic [ssg_pkg::AMP_W-1:0]       amplitude_i,
  input  logic                            out_ready_i,
  output logic                            ready_o,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]   sample_o,
  output logic [ssg_pkg::INDEX_W-1:0]     sample_index_o,
  output logic                            last_o
);
  import ssg_pkg::*;

  localparam int PW = AMP_W + SAMPLE_BITS + 1;

  tag_t                   tag_q;
  logic                   s1_v_q, s1_v_d;
  logic                   out_v_q, out_v_d;
  logic                   s1_take;
  logic [PW-1:0]          prod;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [INDEX_W-1:0]     idx_q;
  logic                   last_q;

  assign s1_take = s1_v_q && (!out_v_q || out_ready_i);
  assign ready_o = !s1_v_q || s1_take;

  // round to nearest on the q1.x product
  assign prod = PW'(amplitude_i) * PW'(entry_i) + (PW'(1) << (SAMPLE_BITS - 2));
  assign mag  = SAMPLE_BITS'(prod >> (SAMPLE_BITS - 1));
  assign smp  = tag_q.neg ? -mag : mag;

  always_comb begin
    if (accept_i) begin
      s1_v_d = 1'b1;
    end else if (s1_take) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  always_comb begin
    if (s1_take) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      tag_q <= tag_i;
    end
    if (s1_take) begin
      smp_q  <= smp;
      idx_q  <= tag_q.index;
      last_q <= tag_q.last;
    end
  end

  assign out_valid_o    = out_v_q;
  assign sample_o       = signed'(smp_q);
  assign sample_index_o = idx_q;
  assign last_o         = last_q;

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_v_q && !out_ready_i |=> s1_v_q && $stable(tag_q))
    else $error("stalled request lost in table stage");

endmodule

// ===== src/sine_sample_generator_unit.sv =====
// sine sample generator, direct digital synthesis
// input channel: in_valid_i / in_ready_o with restart_i; each request yields
//   exactly one sample. restart_i = 1 zeroes phase and index first.
// output channel: out_valid_o / out_ready_i with sample_o, sample_index_o and
//   last_o; last_o marks index sample_count-1 (at most 65535; a count of zero
//   acts as one), after which index and phase return to zero.
// config: apb-style port, phase_step at 0x0, amplitude at 0x4, sample_count
//   at 0x8; pready is tied high; write only while no request is in flight.
// pipeline: request to table read register, then scale and output register.
// throughput: one request per cycle unless held; a stalled output holds its result
//   and the table stage; in_ready_o drops only when both are full or during fill.
// reset: the quarter-wave table ram is loaded from constants by a sweep of
//   all 2^TABLE_ADDR_BITS entries (1024 at default), during which in_ready_o
//   stays low; config writes are taken throughout.
module sine_sample_generator_unit #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   sample_o,
  output logic [ssg_pkg::INDEX_W-1:0]     sample_index_o,
  output logic                            last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ssg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ssg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ssg_pkg::*;

  localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;

  cfg_t                       cfg;
  tag_t                       tag;
  logic                       fill_busy;
  logic                       wr_en;
  logic [TABLE_ADDR_BITS-1:0] wr_addr;
  logic [SAMPLE_BITS-1:0]     wr_data;
  logic [TABLE_ADDR_BITS-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0]     rd_data;
  logic                       stage_ready;
  logic                       accept;

  assign in_ready_o = !fill_busy && stage_ready;
  assign accept     = in_valid_i && in_ready_o;

  ssg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssg_rom_fill #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (fill_busy),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  ssg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ssg_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (restart_i),
    .cfg_i     (cfg),
    .rd_addr_o (rd_addr),
    .tag_o     (tag)
  );

  ssg_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .tag_i          (tag),
    .entry_i        (rd_data),
    .amplitude_i    (cfg.amplitude),
    .out_ready_i    (out_ready_i),
    .ready_o        (stage_ready),
    .out_valid_o    (out_valid_o),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_o         (last_o)
  );

  a_no_read_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !fill_busy && !wr_en)
    else $error("request taken while table is loading");

endmodule
